// ===== hdl/assert_macros.svh =====
// Assertion macros used by the resolver datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, masked during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/arc_pkg.sv =====
// Shared types and constants for the ARP resolver cache.
`default_nettype none
package arc_pkg;

  // Table depth defaults
  localparam int DEF_CACHE_ENTRIES   = 16;
  localparam int DEF_PENDING_ENTRIES = 16;
  localparam int DEF_HOLDOFF_ENTRIES = 8;

  // Results released per received reply
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = 5;

  // Field widths
  localparam int MAC_W  = 48;
  localparam int IP_W   = 32;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 64;
  localparam int MS_W   = 32;
  localparam int IN_DATA_W  = 280;
  localparam int OUT_DATA_W = 96;

  // Input selector codes
  localparam logic [1:0] ACT_SEND  = 2'd0;
  localparam logic [1:0] ACT_FRAME = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_IPV4    = 3'd0;
  localparam logic [2:0] KIND_ARP_REQ = 3'd1;
  localparam logic [2:0] KIND_ARP_REP = 3'd2;
  localparam logic [2:0] KIND_DELIVER = 3'd3;
  localparam logic [2:0] KIND_DROPPED = 3'd4;

  // Protocol constants
  localparam logic [15:0]      ETH_IPV4   = 16'h0800;
  localparam logic [15:0]      ETH_ARP    = 16'h0806;
  localparam logic [15:0]      ARP_OP_REQ = 16'd1;
  localparam logic [MAC_W-1:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes and reset values
  localparam logic [1:0] REG_OWN_MAC  = 2'd0;
  localparam logic [1:0] REG_OWN_IP   = 2'd1;
  localparam logic [1:0] REG_LIFETIME = 2'd2;
  localparam logic [1:0] REG_HOLDOFF  = 2'd3;
  localparam logic [MS_W-1:0] DEF_LIFETIME_MS = 32'd30000;
  localparam logic [MS_W-1:0] DEF_HOLDOFF_MS  = 32'd5000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_C_RD, ST_C_CHK, ST_SEND_HIT, ST_H_RD, ST_H_CHK,
    ST_SEND_POST, ST_SEND_DROP, ST_SEND_REQ, ST_ARP_WR, ST_ARP_REPLY,
    ST_P_RD, ST_P_CHK, ST_P_FIN, ST_P_LAST, ST_DELIVER
  } state_t;

  typedef enum logic [2:0] {
    EM_HIT, EM_DROP, EM_REQ, EM_REPLY, EM_FWD, EM_FWD_LAST, EM_DELIVER
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      scan_clr;
    logic      cache_chk;
    logic      hold_chk;
    logic      pend_chk;
    logic      idx_inc;
    logic      cache_wr;
    logic      hold_wr;
    logic      pend_push;
    logic      cnt_set;
    logic      time_add;
    logic      emit;
    emit_sel_t emit_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       arp_ok;
    logic       ipv4_ok;
    logic       op_req;
    logic       cache_live;
    logic       c_last;
    logic       h_last;
    logic       p_last;
    logic       pend_full;
    logic       pend_empty;
    logic       held;
    logic       p_match;
    logic       fwd_valid;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/arp_resolver_cache_core.sv =====
// Top level of the ARP resolver cache: stream ports, sequencer and datapath.
// One request at a time; each table entry is visited by a read state and a check state (registered RAM read).
// Send: walks the cache table, stopping at a live hit; on a miss it also walks the hold-off table (plus a drop).
// ARP frame: walks the cache table and writes the sender; a request then replies, a reply releases queued tags.
// IPv4 deliver and tick walk no table; results leave through one output register, a stalled sink holds the walk.
// Reset (rst, synchronous): clears time, valid bits, pending count; config returns to defaults; RAMs not swept.
`default_nettype none
module arp_resolver_cache_core #(
  parameter int CACHE_ENTRIES   = arc_pkg::DEF_CACHE_ENTRIES,
  parameter int PENDING_ENTRIES = arc_pkg::DEF_PENDING_ENTRIES,
  parameter int HOLDOFF_ENTRIES = arc_pkg::DEF_HOLDOFF_ENTRIES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  // next_hop_ip[31:0], datagram_tag[47:32], frame_dst_mac[95:48], frame_type[111:96],
  // payload_ok[112], arp_opcode[128:113], arp_sender_ip[160:129],
  // arp_sender_mac[208:161], arp_target_ip[240:209], elapsed_ms[272:241], zero pad
  input  wire logic [arc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [1:0]                     s_tuser,   // action[1:0]
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  // out_dst_mac[47:0], out_target_ip[79:48], out_tag[95:80]
  output      logic [arc_pkg::OUT_DATA_W-1:0] m_tdata,
  output      logic [2:0]                     m_tuser,   // out_kind[2:0]
  output      logic                           m_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [arc_pkg::MAC_W-1:0]      cfg_wdata
);
  arc_pkg::ctrl_cmd_t  cmd;
  arc_pkg::dp_status_t st;

  arc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  arc_dp #(
    .CACHE_ENTRIES   (CACHE_ENTRIES),
    .PENDING_ENTRIES (PENDING_ENTRIES),
    .HOLDOFF_ENTRIES (HOLDOFF_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );
endmodule
`default_nettype wire

// ===== hdl/arc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [AW-1:0]         raddr,
  output      logic [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/arc_ctrl.sv =====
// Sequencer for the resolver: walks the tables and paces result output.
`default_nettype none
module arc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire arc_pkg::dp_status_t st,
  output      arc_pkg::ctrl_cmd_t  cmd
);
  arc_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      arc_pkg::ST_IDLE: begin
        if (in_valid) state_next = arc_pkg::ST_DECODE;
      end
      arc_pkg::ST_DECODE: begin
        if (st.action == arc_pkg::ACT_SEND) begin
          state_next = arc_pkg::ST_C_RD;
        end else if (st.action == arc_pkg::ACT_FRAME && st.arp_ok) begin
          state_next = arc_pkg::ST_C_RD;
        end else if (st.action == arc_pkg::ACT_FRAME && st.ipv4_ok) begin
          state_next = arc_pkg::ST_DELIVER;
        end else begin
          state_next = arc_pkg::ST_IDLE;
        end
      end
      arc_pkg::ST_C_RD: state_next = arc_pkg::ST_C_CHK;
      arc_pkg::ST_C_CHK: begin
        if (st.action == arc_pkg::ACT_SEND && st.cache_live) begin
          state_next = arc_pkg::ST_SEND_HIT;
        end else if (st.c_last) begin
          state_next = (st.action == arc_pkg::ACT_SEND) ? arc_pkg::ST_H_RD
                                                        : arc_pkg::ST_ARP_WR;
        end else begin
          state_next = arc_pkg::ST_C_RD;
        end
      end
      arc_pkg::ST_H_RD: state_next = arc_pkg::ST_H_CHK;
      arc_pkg::ST_H_CHK: begin
        state_next = st.h_last ? arc_pkg::ST_SEND_POST : arc_pkg::ST_H_RD;
      end
      arc_pkg::ST_SEND_POST: begin
        if (st.pend_full) state_next = arc_pkg::ST_SEND_DROP;
        else if (!st.held) state_next = arc_pkg::ST_SEND_REQ;
        else state_next = arc_pkg::ST_IDLE;
      end
      arc_pkg::ST_SEND_DROP: begin
        if (st.out_free) state_next = st.held ? arc_pkg::ST_IDLE : arc_pkg::ST_SEND_REQ;
      end
      arc_pkg::ST_SEND_REQ, arc_pkg::ST_SEND_HIT, arc_pkg::ST_DELIVER,
      arc_pkg::ST_ARP_REPLY, arc_pkg::ST_P_LAST: begin
        if (st.out_free) state_next = arc_pkg::ST_IDLE;
      end
      arc_pkg::ST_ARP_WR: begin
        if (st.op_req) state_next = arc_pkg::ST_ARP_REPLY;
        else if (st.pend_empty) state_next = arc_pkg::ST_P_FIN;
        else state_next = arc_pkg::ST_P_RD;
      end
      arc_pkg::ST_P_RD: state_next = arc_pkg::ST_P_CHK;
      arc_pkg::ST_P_CHK: begin
        if (!(st.p_match && st.fwd_valid && !st.out_free)) begin
          state_next = st.p_last ? arc_pkg::ST_P_FIN : arc_pkg::ST_P_RD;
        end
      end
      arc_pkg::ST_P_FIN: begin
        state_next = st.fwd_valid ? arc_pkg::ST_P_LAST : arc_pkg::ST_IDLE;
      end
      default: state_next = arc_pkg::ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    cmd.emit_sel = arc_pkg::EM_HIT;
    unique case (state)
      arc_pkg::ST_IDLE: begin
        cmd.load     = in_valid;
        cmd.scan_clr = in_valid;
      end
      arc_pkg::ST_DECODE: cmd.time_add = (st.action == arc_pkg::ACT_TICK);
      arc_pkg::ST_C_CHK: begin
        cmd.cache_chk = 1'b1;
        cmd.idx_inc   = 1'b1;
        // restart the walk for the hold-off table
        cmd.scan_clr  = st.c_last && (st.action == arc_pkg::ACT_SEND) && !st.cache_live;
      end
      arc_pkg::ST_H_CHK: begin
        cmd.hold_chk = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      arc_pkg::ST_SEND_POST: cmd.pend_push = !st.pend_full;
      arc_pkg::ST_SEND_DROP: begin
        cmd.emit     = st.out_free;
        cmd.emit_sel = arc_pkg::EM_DROP;
      end
      arc_pkg::ST_SEND_REQ: begin
        cmd.emit     = st.out_free;
        cmd.hold_wr  = st.out_free;
        cmd.emit_sel = arc_pkg::EM_REQ;
      end
      arc_pkg::ST_SEND_HIT: begin
        cmd.emit     = st.out_free;
        cmd.emit_sel = arc_pkg::EM_HIT;
      end
      arc_pkg::ST_DELIVER: begin
        cmd.emit     = st.out_free;
        cmd.emit_sel = arc_pkg::EM_DELIVER;
      end
      arc_pkg::ST_ARP_WR: begin
        cmd.cache_wr = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      arc_pkg::ST_ARP_REPLY: begin
        cmd.emit     = st.out_free;
        cmd.emit_sel = arc_pkg::EM_REPLY;
      end
      arc_pkg::ST_P_CHK: begin
        // hold while an earlier released tag cannot be pushed out
        if (!(st.p_match && st.fwd_valid && !st.out_free)) begin
          cmd.pend_chk = 1'b1;
          cmd.idx_inc  = 1'b1;
          cmd.emit     = st.p_match && st.fwd_valid;
          cmd.emit_sel = arc_pkg::EM_FWD;
        end
      end
      arc_pkg::ST_P_FIN: cmd.cnt_set = 1'b1;
      arc_pkg::ST_P_LAST: begin
        cmd.emit     = st.out_free;
        cmd.emit_sel = arc_pkg::EM_FWD_LAST;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == arc_pkg::ST_IDLE);
endmodule
`default_nettype wire

// ===== hdl/arc_dp.sv =====
// Datapath: item and config registers, tables, scan trackers, result register.
`default_nettype none
`include "assert_macros.svh"
module arc_dp #(
  parameter int CACHE_ENTRIES   = arc_pkg::DEF_CACHE_ENTRIES,
  parameter int PENDING_ENTRIES = arc_pkg::DEF_PENDING_ENTRIES,
  parameter int HOLDOFF_ENTRIES = arc_pkg::DEF_HOLDOFF_ENTRIES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [arc_pkg::IN_DATA_W-1:0]   in_data,
  input  wire logic [1:0]                      in_user,
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [arc_pkg::MAC_W-1:0]       cfg_wdata,
  input  wire arc_pkg::ctrl_cmd_t              cmd,
  output      arc_pkg::dp_status_t             st,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [arc_pkg::OUT_DATA_W-1:0]  out_data,
  output      logic [2:0]                      out_kind,
  output      logic                            out_last
);
  localparam int CW   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int HW   = (HOLDOFF_ENTRIES > 1) ? $clog2(HOLDOFF_ENTRIES) : 1;
  localparam int PW   = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int PCW  = $clog2(PENDING_ENTRIES + 1);
  localparam int MAXD = (CACHE_ENTRIES > PENDING_ENTRIES)
                      ? ((CACHE_ENTRIES > HOLDOFF_ENTRIES) ? CACHE_ENTRIES : HOLDOFF_ENTRIES)
                      : ((PENDING_ENTRIES > HOLDOFF_ENTRIES) ? PENDING_ENTRIES
                                                             : HOLDOFF_ENTRIES);
  localparam int IW   = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int XW   = ((IW > PCW) ? IW : PCW) + 1;
  localparam int CE_W = arc_pkg::IP_W + arc_pkg::MAC_W + arc_pkg::TIME_W;
  localparam int HE_W = arc_pkg::IP_W + arc_pkg::TIME_W;
  localparam int PE_W = arc_pkg::IP_W + arc_pkg::TAG_W;

  // Configuration registers
  logic [arc_pkg::MAC_W-1:0] own_mac;
  logic [arc_pkg::IP_W-1:0]  own_ip;
  logic [arc_pkg::MS_W-1:0]  lifetime_ms;
  logic [arc_pkg::MS_W-1:0]  holdoff_ms;

  // Captured item
  logic [1:0]                 action;
  logic [arc_pkg::IP_W-1:0]   hop_ip;
  logic [arc_pkg::TAG_W-1:0]  tag;
  logic [arc_pkg::MAC_W-1:0]  dst_mac;
  logic [15:0]                ftype;
  logic                       pay_ok;
  logic [15:0]                opcode;
  logic [arc_pkg::IP_W-1:0]   sender_ip;
  logic [arc_pkg::MAC_W-1:0]  sender_mac;
  logic [arc_pkg::IP_W-1:0]   target_ip;
  logic [arc_pkg::MS_W-1:0]   elapsed;

  // Control state
  logic [arc_pkg::TIME_W-1:0]   now;
  logic [CACHE_ENTRIES-1:0]     cache_valid;
  logic [HOLDOFF_ENTRIES-1:0]   hold_valid;
  logic [PCW-1:0]               pend_cnt;
  logic [PCW-1:0]               wr_ptr;
  logic [IW-1:0]                idx;
  logic [arc_pkg::RES_CNT_W-1:0] res_cnt;
  logic                         fwd_valid;
  logic                         held;
  logic                         same_found;
  logic                         free_found;

  // Scan payload
  logic [IW-1:0]               same_idx;
  logic [IW-1:0]               free_idx;
  logic [IW-1:0]               min_idx;
  logic [arc_pkg::TIME_W-1:0]  min_val;
  logic [arc_pkg::MAC_W-1:0]   hit_mac;
  logic [arc_pkg::TAG_W-1:0]   fwd_tag;

  // Table ports
  logic [CE_W-1:0] c_rdata;
  logic [HE_W-1:0] h_rdata;
  logic [PE_W-1:0] p_rdata;
  logic            p_we;
  logic [PW-1:0]   p_waddr;
  logic [PE_W-1:0] p_wdata;

  // Derived values
  logic [arc_pkg::IP_W-1:0]   key;
  logic [arc_pkg::IP_W-1:0]   c_ip;
  logic [arc_pkg::MAC_W-1:0]  c_mac;
  logic [arc_pkg::TIME_W-1:0] c_exp;
  logic [arc_pkg::IP_W-1:0]   h_ip;
  logic [arc_pkg::TIME_W-1:0] h_dl;
  logic [arc_pkg::IP_W-1:0]   p_ip;
  logic [arc_pkg::TAG_W-1:0]  p_tag;
  logic                       sel_valid;
  logic [arc_pkg::IP_W-1:0]   sel_ip;
  logic [arc_pkg::TIME_W-1:0] sel_time;
  logic                       sel_match;
  logic                       c_live;
  logic                       p_match;
  logic [IW-1:0]              slot;
  logic                       dst_ok;
  logic                       out_free;

  assign key   = (action == arc_pkg::ACT_SEND) ? hop_ip : sender_ip;
  assign c_ip  = c_rdata[CE_W-1 -: arc_pkg::IP_W];
  assign c_mac = c_rdata[arc_pkg::TIME_W +: arc_pkg::MAC_W];
  assign c_exp = c_rdata[arc_pkg::TIME_W-1:0];
  assign h_ip  = h_rdata[HE_W-1 -: arc_pkg::IP_W];
  assign h_dl  = h_rdata[arc_pkg::TIME_W-1:0];
  assign p_ip  = p_rdata[PE_W-1 -: arc_pkg::IP_W];
  assign p_tag = p_rdata[arc_pkg::TAG_W-1:0];

  // Select the entry under inspection
  assign sel_valid = cmd.cache_chk ? cache_valid[idx[CW-1:0]] : hold_valid[idx[HW-1:0]];
  assign sel_ip    = cmd.cache_chk ? c_ip : h_ip;
  assign sel_time  = cmd.cache_chk ? c_exp : h_dl;
  assign sel_match = sel_valid && (sel_ip == key);
  assign c_live    = cache_valid[idx[CW-1:0]] && (c_ip == key) && (c_exp >= now);
  assign p_match   = (p_ip == sender_ip) &&
                     (res_cnt < arc_pkg::RES_CNT_W'(arc_pkg::MAX_RESULTS));
  assign slot      = same_found ? same_idx : (free_found ? free_idx : min_idx);
  assign dst_ok    = (dst_mac == own_mac) || (dst_mac == arc_pkg::BCAST_MAC);
  assign out_free  = !out_valid || out_ready;

  // Status toward the sequencer
  always_comb begin
    st.action     = action;
    st.arp_ok     = dst_ok && (ftype == arc_pkg::ETH_ARP) && pay_ok && (target_ip == own_ip);
    st.ipv4_ok    = dst_ok && (ftype == arc_pkg::ETH_IPV4) && pay_ok;
    st.op_req     = (opcode == arc_pkg::ARP_OP_REQ);
    st.cache_live = c_live;
    st.c_last     = (idx == IW'(CACHE_ENTRIES - 1));
    st.h_last     = (idx == IW'(HOLDOFF_ENTRIES - 1));
    st.p_last     = (XW'(idx) + XW'(1)) == XW'(pend_cnt);
    st.pend_full  = (pend_cnt == PCW'(PENDING_ENTRIES));
    st.pend_empty = (pend_cnt == '0);
    st.held       = held;
    st.p_match    = p_match;
    st.fwd_valid  = fwd_valid;
    st.out_free   = out_free;
  end

  // Pending write port: append on send, compact on release walk
  assign p_we    = cmd.pend_push || (cmd.pend_chk && !p_match);
  assign p_waddr = cmd.pend_push ? pend_cnt[PW-1:0] : wr_ptr[PW-1:0];
  assign p_wdata = cmd.pend_push ? {hop_ip, tag} : p_rdata;

  arc_ram #(.WIDTH(CE_W), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
    .clk   (clk),
    .we    (cmd.cache_wr),
    .waddr (slot[CW-1:0]),
    .wdata ({sender_ip, sender_mac, now + arc_pkg::TIME_W'(lifetime_ms)}),
    .raddr (idx[CW-1:0]),
    .rdata (c_rdata)
  );

  arc_ram #(.WIDTH(HE_W), .DEPTH(HOLDOFF_ENTRIES)) u_hold_ram (
    .clk   (clk),
    .we    (cmd.hold_wr),
    .waddr (slot[HW-1:0]),
    .wdata ({hop_ip, now + arc_pkg::TIME_W'(holdoff_ms)}),
    .raddr (idx[HW-1:0]),
    .rdata (h_rdata)
  );

  arc_ram #(.WIDTH(PE_W), .DEPTH(PENDING_ENTRIES)) u_pend_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (idx[PW-1:0]),
    .rdata (p_rdata)
  );

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action     <= in_user;
      hop_ip     <= in_data[31:0];
      tag        <= in_data[47:32];
      dst_mac    <= in_data[95:48];
      ftype      <= in_data[111:96];
      pay_ok     <= in_data[112];
      opcode     <= in_data[128:113];
      sender_ip  <= in_data[160:129];
      sender_mac <= in_data[208:161];
      target_ip  <= in_data[240:209];
      elapsed    <= in_data[272:241];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac     <= '0;
      own_ip      <= '0;
      lifetime_ms <= arc_pkg::DEF_LIFETIME_MS;
      holdoff_ms  <= arc_pkg::DEF_HOLDOFF_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arc_pkg::REG_OWN_MAC:  own_mac     <= cfg_wdata;
        arc_pkg::REG_OWN_IP:   own_ip      <= cfg_wdata[arc_pkg::IP_W-1:0];
        arc_pkg::REG_LIFETIME: lifetime_ms <= cfg_wdata[arc_pkg::MS_W-1:0];
        arc_pkg::REG_HOLDOFF:  holdoff_ms  <= cfg_wdata[arc_pkg::MS_W-1:0];
      endcase
    end
  end

  // Control state: clock, valid bits, walk counters, flags
  always_ff @(posedge clk) begin
    if (rst) begin
      now         <= '0;
      cache_valid <= '0;
      hold_valid  <= '0;
      pend_cnt    <= '0;
      wr_ptr      <= '0;
      idx         <= '0;
      res_cnt     <= '0;
      fwd_valid   <= 1'b0;
      held        <= 1'b0;
      same_found  <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (cmd.time_add) now <= now + arc_pkg::TIME_W'(elapsed);
      if (cmd.cache_wr) cache_valid[slot[CW-1:0]] <= 1'b1;
      if (cmd.hold_wr) hold_valid[slot[HW-1:0]] <= 1'b1;
      if (cmd.pend_push) pend_cnt <= pend_cnt + PCW'(1);
      if (cmd.cnt_set) pend_cnt <= wr_ptr;
      if (cmd.scan_clr) begin
        idx        <= '0;
        wr_ptr     <= '0;
        res_cnt    <= '0;
        fwd_valid  <= 1'b0;
        held       <= 1'b0;
        same_found <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.idx_inc) idx <= idx + IW'(1);
        if (cmd.cache_chk || cmd.hold_chk) begin
          if (sel_match) same_found <= 1'b1;
          if (!sel_valid) free_found <= 1'b1;
        end
        if (cmd.hold_chk && sel_match && (h_dl >= now)) held <= 1'b1;
        if (cmd.pend_chk) begin
          if (p_match) begin
            fwd_valid <= 1'b1;
            res_cnt   <= res_cnt + arc_pkg::RES_CNT_W'(1);
          end else begin
            wr_ptr <= wr_ptr + PCW'(1);
          end
        end
        if (cmd.emit && cmd.emit_sel == arc_pkg::EM_FWD_LAST) fwd_valid <= 1'b0;
      end
    end
  end

  // Scan payload: first same key, first free slot, soonest deadline, hit MAC, released tag
  always_ff @(posedge clk) begin
    if (cmd.cache_chk || cmd.hold_chk) begin
      if (sel_match && !same_found) same_idx <= idx;
      if (!sel_valid && !free_found) free_idx <= idx;
      if (idx == '0 || sel_time < min_val) begin
        min_val <= sel_time;
        min_idx <= idx;
      end
    end
    if (cmd.cache_chk && c_live) hit_mac <= c_mac;
    if (cmd.pend_chk && p_match) fwd_tag <= p_tag;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.emit_sel)
        arc_pkg::EM_HIT: begin
          out_kind <= arc_pkg::KIND_IPV4;
          out_data <= {tag, 32'd0, hit_mac};
          out_last <= 1'b1;
        end
        arc_pkg::EM_DROP: begin
          out_kind <= arc_pkg::KIND_DROPPED;
          out_data <= {tag, 32'd0, 48'd0};
          out_last <= held;
        end
        arc_pkg::EM_REQ: begin
          out_kind <= arc_pkg::KIND_ARP_REQ;
          out_data <= {16'd0, hop_ip, arc_pkg::BCAST_MAC};
          out_last <= 1'b1;
        end
        arc_pkg::EM_REPLY: begin
          out_kind <= arc_pkg::KIND_ARP_REP;
          out_data <= {16'd0, sender_ip, sender_mac};
          out_last <= 1'b1;
        end
        arc_pkg::EM_FWD: begin
          out_kind <= arc_pkg::KIND_IPV4;
          out_data <= {fwd_tag, 32'd0, sender_mac};
          out_last <= 1'b0;
        end
        arc_pkg::EM_FWD_LAST: begin
          out_kind <= arc_pkg::KIND_IPV4;
          out_data <= {fwd_tag, 32'd0, sender_mac};
          out_last <= 1'b1;
        end
        arc_pkg::EM_DELIVER: begin
          out_kind <= arc_pkg::KIND_DELIVER;
          out_data <= {tag, 32'd0, 48'd0};
          out_last <= 1'b1;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_emit_free, cmd.emit |-> out_free, "result emitted into a busy output register")
  `ASSERT_NEVER(a_cnt_range, pend_cnt > PCW'(PENDING_ENTRIES), "pending count beyond depth")
  `ASSERT_NEVER(a_wr_behind, cmd.pend_chk && (XW'(wr_ptr) > XW'(idx)), "compaction overtook read")
  `ASSERT_NEVER(a_res_cap, res_cnt > arc_pkg::RES_CNT_W'(arc_pkg::MAX_RESULTS), "release cap broken")
endmodule
`default_nettype wire
